/* src/ipv6_ext_header_skipper_defines.svh */
// -----------------------------------------------------------------------------
// ipv6_ext_header_skipper_defines.svh
// Assertion macros for the IPv6 extension header skipper. The including
// module must have clk and rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef IPV6_EXT_HEADER_SKIPPER_DEFINES_SVH
`define IPV6_EXT_HEADER_SKIPPER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define IHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihs assertion failed");
// Next-cycle implication
`define IHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihs assertion failed");
`else
`define IHS_ASSERT_NOW(label, ante, cons)
`define IHS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/ihs_pkg.sv */
// -----------------------------------------------------------------------------
// ihs_pkg
// Shared types, protocol numbers and offset sizing for the IPv6 extension
// header skipper.
// -----------------------------------------------------------------------------
package ihs_pkg;

    localparam int OFFSET_BITS = 16;
    // Accumulator holds a 16-bit start offset or an offset up to the limit,
    // plus one carry bit for the overflow check.
    localparam int ACC_W = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;
    localparam logic [ACC_W-1:0] OFFSET_MAX = ACC_W'((64'd1 << OFFSET_BITS) - 64'd1);

    localparam logic [7:0] NH_HOP      = 8'd0;
    localparam logic [7:0] NH_ROUTING  = 8'd43;
    localparam logic [7:0] NH_FRAGMENT = 8'd44;
    localparam logic [7:0] NH_AUTH     = 8'd51;
    localparam logic [7:0] NH_NONE     = 8'd59;
    localparam logic [7:0] NH_DEST     = 8'd60;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_packet;
        logic        last_of_packet;
        logic [7:0]  initial_next_header;
        logic [15:0] start_offset;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  final_next_header;
        logic [15:0] end_offset;
    } out_word_t;

    function automatic logic is_ext(input logic [7:0] nh);
        return nh inside {NH_HOP, NH_ROUTING, NH_FRAGMENT, NH_AUTH, NH_NONE, NH_DEST};
    endfunction

endpackage

/* src/ihs_in_if.sv */
// -----------------------------------------------------------------------------
// ihs_in_if
// Valid/ready channel carrying one packet byte word.
// -----------------------------------------------------------------------------
interface ihs_in_if;
    logic             valid;
    logic             ready;
    ihs_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ihs_out_if.sv */
// -----------------------------------------------------------------------------
// ihs_out_if
// Valid/ready channel carrying one chain walk result word.
// -----------------------------------------------------------------------------
interface ihs_out_if;
    logic              valid;
    logic              ready;
    ihs_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ipv6_ext_header_skipper.sv */
// -----------------------------------------------------------------------------
// ipv6_ext_header_skipper: IPv6 extension header chain walker
// Takes one packet byte word per cycle while no result waits untaken; the
// result word for the byte that resolves the chain passes through the input
// register, then the result register.
// Asynchronous active-low reset empties both registers and idles until a first byte.
// -----------------------------------------------------------------------------
module ipv6_ext_header_skipper (
    input  logic       clk,
    input  logic       rst_n,
    ihs_in_if.sink     pkt,
    ihs_out_if.source  result
);

    ihs_in_if held ();

    ihs_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .held  (held)
    );

    ihs_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .held   (held),
        .result (result)
    );

endmodule

/* src/ihs_in_reg.sv */
// -----------------------------------------------------------------------------
// ihs_in_reg
// Input register stage: captures one byte word per cycle while empty or while
// the walker takes the held word, and hands it to the chain walker.
// -----------------------------------------------------------------------------
module ihs_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    ihs_in_if.sink     pkt,
    ihs_in_if.source   held
);

    logic              valid_reg;
    logic              valid_next;
    ihs_pkg::in_word_t word_reg;

    // Take a new word when empty or when the held word moves on
    assign pkt.ready  = !valid_reg || held.ready;
    assign held.valid = valid_reg;
    assign held.data  = word_reg;

    always_comb
    begin
        if (pkt.valid && pkt.ready)
        begin
            valid_next = 1'b1;
        end
        else if (held.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            word_reg <= pkt.data;
        end
    end

endmodule

/* src/ihs_walker.sv */
// -----------------------------------------------------------------------------
// ihs_walker
// Extension header chain state and result register: one byte word per
// cycle while no result waits untaken, one result word per packet.
// -----------------------------------------------------------------------------
`include "ipv6_ext_header_skipper_defines.svh"

module ihs_walker (
    input  logic       clk,
    input  logic       rst_n,
    ihs_in_if.sink     held,
    ihs_out_if.source  result
);

    localparam int AW = ihs_pkg::ACC_W;

    logic [7:0]    nh_reg,   nh_next;
    logic [AW-1:0] acc_reg,  acc_next;
    logic [11:0]   bih_reg,  bih_next;
    logic [11:0]   hl_reg,   hl_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    fh_reg,   fh_next;
    logic          done_reg, done_next;

    logic               res_valid_reg;
    ihs_pkg::out_word_t res_word_reg;
    ihs_pkg::out_word_t res_word_next;

    logic          go;
    logic          step;
    logic          hit;
    logic [AW-1:0] acc_sum;
    logic [15:0]   frag_word;

    // Hold the stream while a result waits and is not taken
    assign go         = !res_valid_reg || result.ready;
    assign step       = held.valid && go;
    assign held.ready = go;

    assign result.valid = res_valid_reg;
    assign result.data  = res_word_reg;

    always_comb
    begin
        nh_next       = nh_reg;
        acc_next      = acc_reg;
        bih_next      = bih_reg;
        hl_next       = hl_reg;
        pend_next     = pend_reg;
        fh_next       = fh_reg;
        done_next     = done_reg;
        hit           = 1'b0;
        acc_sum       = '0;
        frag_word     = {fh_reg, held.data.data_byte};
        res_word_next = '0;

        if (step)
        begin
            if (held.data.first_of_packet)
            begin
                nh_next   = held.data.initial_next_header;
                acc_next  = AW'(held.data.start_offset);
                bih_next  = '0;
                hl_next   = '0;
                pend_next = '0;
                fh_next   = '0;
                done_next = 1'b0;
                if (acc_next > ihs_pkg::OFFSET_MAX)
                begin
                    hit           = 1'b1;
                    res_word_next = '{ihs_pkg::STATUS_ERR, nh_next, acc_next[15:0]};
                end
                else if (nh_next == ihs_pkg::NH_NONE)
                begin
                    hit           = 1'b1;
                    res_word_next = '{ihs_pkg::STATUS_ERR, nh_next, acc_next[15:0]};
                end
                else if (!ihs_pkg::is_ext(nh_next))
                begin
                    hit           = 1'b1;
                    res_word_next = '{ihs_pkg::STATUS_OK, nh_next, acc_next[15:0]};
                end
            end

            if (!hit && !done_next)
            begin
                if (bih_next == 12'd0)
                begin
                    pend_next = held.data.data_byte;
                end
                else if (bih_next == 12'd1)
                begin
                    if (nh_next == ihs_pkg::NH_FRAGMENT)
                    begin
                        hl_next = 12'd8;
                    end
                    else if (nh_next == ihs_pkg::NH_AUTH)
                    begin
                        hl_next = (12'(held.data.data_byte) + 12'd2) << 2;
                    end
                    else
                    begin
                        hl_next = (12'(held.data.data_byte) + 12'd1) << 3;
                    end
                end
                else if (nh_next == ihs_pkg::NH_FRAGMENT && bih_next == 12'd2)
                begin
                    fh_next = held.data.data_byte;
                end
                else if (nh_next == ihs_pkg::NH_FRAGMENT && bih_next == 12'd3)
                begin
                    // Stop at a fragment that is not the first one
                    if (frag_word[15:3] != 13'd0)
                    begin
                        hit           = 1'b1;
                        res_word_next = '{ihs_pkg::STATUS_OK, ihs_pkg::NH_FRAGMENT,
                                          acc_next[15:0]};
                    end
                end

                if (!hit)
                begin
                    if (bih_next != 12'd0 && ({1'b0, bih_next} + 13'd1) >= {1'b0, hl_next})
                    begin
                        // End of this header: advance to the next one
                        acc_sum = acc_next + AW'(hl_next);
                        if (acc_sum > ihs_pkg::OFFSET_MAX)
                        begin
                            hit           = 1'b1;
                            res_word_next = '{ihs_pkg::STATUS_ERR, nh_next, acc_next[15:0]};
                        end
                        else
                        begin
                            acc_next = acc_sum;
                            nh_next  = pend_next;
                            bih_next = '0;
                            if (nh_next == ihs_pkg::NH_NONE)
                            begin
                                hit           = 1'b1;
                                res_word_next = '{ihs_pkg::STATUS_ERR, nh_next,
                                                  acc_next[15:0]};
                            end
                            else if (!ihs_pkg::is_ext(nh_next))
                            begin
                                hit           = 1'b1;
                                res_word_next = '{ihs_pkg::STATUS_OK, nh_next,
                                                  acc_next[15:0]};
                            end
                        end
                    end
                    else
                    begin
                        bih_next = bih_next + 12'd1;
                    end

                    // Packet ended before the chain resolved
                    if (!hit && held.data.last_of_packet)
                    begin
                        hit           = 1'b1;
                        res_word_next = '{ihs_pkg::STATUS_ERR, nh_next, acc_next[15:0]};
                    end
                end
            end

            if (hit)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nh_reg        <= '0;
            acc_reg       <= '0;
            bih_reg       <= '0;
            hl_reg        <= '0;
            pend_reg      <= '0;
            fh_reg        <= '0;
            done_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            nh_reg   <= nh_next;
            acc_reg  <= acc_next;
            bih_reg  <= bih_next;
            hl_reg   <= hl_next;
            pend_reg <= pend_next;
            fh_reg   <= fh_next;
            done_reg <= done_next;
            if (step)
            begin
                res_valid_reg <= hit;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hit)
        begin
            res_word_reg <= res_word_next;
        end
    end

    `IHS_ASSERT_NEXT(a_result_ends_walk, step && hit, done_reg && res_valid_reg)
    `IHS_ASSERT_NOW(a_stall_on_full_result, res_valid_reg && !result.ready, !step)
    `IHS_ASSERT_NOW(a_byte_count_in_header, !done_reg && bih_reg > 12'd1, bih_reg < hl_reg)
    `IHS_ASSERT_NOW(a_offset_in_range, !done_reg, acc_reg <= ihs_pkg::OFFSET_MAX)

endmodule
